>>> rtl/assert_macros.svh
// Assertion macros shared by the fader RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property under clock and active-low reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition holds at every clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

>>> rtl/rlf_pkg.sv
// Package for the RGB LED linear fader: types, constants and codes
`timescale 1ns / 1ps
package rlf_pkg;
  localparam int unsigned RefreshPeriodMsDef = 32;
  localparam int unsigned DurW = 16;
  localparam int unsigned ColW = 8;
  localparam int unsigned IncW = 9;
  localparam int unsigned ErrW = 19;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_FADE  = 2'd1,
    KIND_STILL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
    logic [DurW-1:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [ColW-1:0] led_red;
    logic [ColW-1:0] led_green;
    logic [ColW-1:0] led_blue;
    logic            fade_active;
  } out_word_t;

  // Divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUR,
    ST_INC,
    ST_TICK,
    ST_OUT
  } state_e;
endpackage

>>> rtl/rlf_if.sv
// Valid/ready channel interface
`timescale 1ns / 1ps
interface rlf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rlf_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned
`timescale 1ns / 1ps
module rlf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rlf_pkg::DurW-1:0]  num_i,
  input  logic [rlf_pkg::DurW-1:0]  den_i,
  output rlf_pkg::div_ctl_t         ctl_o,
  output logic [rlf_pkg::DurW-1:0]  quo_o
);
  import rlf_pkg::*;
  `include "assert_macros.svh"

  logic [DurW-1:0] quo_q, quo_d;
  logic [DurW:0]   rem_q, rem_d;
  logic [DurW-1:0] den_q, den_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DurW:0]   trial;

  // Shift in one numerator bit and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DurW-1:0], quo_q[DurW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 5'(DurW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[DurW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DurW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quo_o = quo_q;

  `ASSERT_PROP(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `ASSERT_ALWAYS(a_not_both, clk_i, rst_ni, !(busy_q && done_q), "busy and done together")
  `ASSERT_PROP(a_cnt_busy, clk_i, rst_ni, busy_q |-> cnt_q != 5'd0, "busy with zero count")
endmodule

>>> rtl/rgb_led_linear_fader_core.sv
// Top level of the RGB LED linear fader
`timescale 1ns / 1ps
// Channel | Dir | Fields
// in_ch   | in  | kind, red, green, blue, duration_ms
// out_ch  | out | led_red, led_green, led_blue, fade_active
// A start-fade word gets its step count from a reciprocal multiply at accept, then passes a
// setup state and one division per channel for the increment. A duration under one refresh
// period ends in the setup state. A tick word while fading steps the channels in ST_TICK,
// one channel a cycle, then loads the output register in ST_OUT; a still tick goes straight
// to ST_OUT and the tick that ends a fade skips the step. A set-colour word ends at accept.
// The block takes no word while busy; a waiting result holds back only the next output load.
// Reset is asynchronous, active low, and clears all fade state to black.
module rgb_led_linear_fader_core #(
  parameter int unsigned RefreshPeriodMs = rlf_pkg::RefreshPeriodMsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rlf_if.sink   in_ch,
  rlf_if.source out_ch
);
  import rlf_pkg::*;
  `include "assert_macros.svh"

  // Reciprocal of the refresh period, exact for every 16-bit duration
  localparam int unsigned PerL = $clog2(RefreshPeriodMs);
  localparam int unsigned RecipS = DurW + PerL;
  localparam int unsigned ProdW = 2 * DurW + 1;
  localparam longint unsigned RecipM =
    (64'd1 << RecipS) / longint'(RefreshPeriodMs) + 64'd1;

  state_e state_q, state_d;
  logic   fading_q, fading_d;
  logic [ColW-1:0] shown_q [3], shown_d [3];
  logic [ColW-1:0] cur_q [3], cur_d [3];
  logic [ColW-1:0] tgt_q [3], tgt_d [3];
  logic signed [IncW-1:0] dif_q [3], dif_d [3];
  logic signed [IncW-1:0] inc_q [3], inc_d [3];
  logic signed [ErrW-1:0] err_q [3], err_d [3];
  logic [DurW-1:0] tot_q, tot_d, left_q, left_d;
  logic [1:0] ch_q, ch_d;
  logic active_q, active_d;
  logic ovalid_q, ovalid_d;
  out_word_t ow_q, ow_d;

  logic div_start;
  logic [DurW-1:0] div_num, div_den, quo;
  div_ctl_t div_ctl;

  rlf_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .ctl_o(div_ctl), .quo_o(quo)
  );

  in_word_t iw;
  logic acc;
  logic out_free;
  assign iw  = in_ch.data;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_q || out_ch.ready;

  // Step count by reciprocal multiply
  logic [ProdW-1:0] dur_prod;
  logic [DurW-1:0]  steps;
  assign dur_prod = ProdW'(iw.duration_ms) * ProdW'(RecipM);
  assign steps    = DurW'(dur_prod >> RecipS);

  // Per-channel advance datapath on the selected channel
  logic signed [10:0] a_cur, a_tgt, a_inc, a_sum, a_res, a_mark2;
  logic signed [ErrW:0] a_err;
  logic signed [ErrW-1:0] a_err_o;
  logic signed [26:0] a_prod, a_mark;
  logic [ColW-1:0] a_sel_cur, a_sel_tgt;
  logic [DurW-1:0] absdif;
  logic [DurW-1:0] left_m1;
  logic signed [IncW-1:0] a_dif;
  always_comb begin
    a_sel_cur = cur_q[ch_q];
    a_sel_tgt = tgt_q[ch_q];
    a_dif   = dif_q[ch_q];
    a_cur   = 11'($signed({3'b0, a_sel_cur}));
    a_tgt   = 11'($signed({3'b0, a_sel_tgt}));
    a_inc   = 11'(inc_q[ch_q]);
    a_sum   = a_cur + a_inc;
    left_m1 = left_q - DurW'(1);
    a_prod  = $signed({1'b0, left_m1}) * 27'(inc_q[ch_q]);
    a_mark  = 27'(a_tgt) - a_prod;
    a_mark2 = a_sum + a_inc;
    a_res   = a_sum;
    a_err   = (ErrW+1)'(err_q[ch_q]);
    a_err_o = err_q[ch_q];
    absdif  = a_dif[IncW-1] ? DurW'(-20'(a_dif)) : DurW'(a_dif);
    if (a_sum < 0) a_res = '0;
    else if (a_sum > 11'sd255) a_res = 11'sd255;
    else if (a_dif > 0) begin
      if (a_sum >= a_tgt) a_res = a_tgt;
      else if (a_inc == 0) begin
        a_err = a_err + (ErrW+1)'({absdif, 1'b0});
        if (a_err > $signed({4'b0, tot_q})) begin
          a_res = a_sum + 11'sd1;
          a_err = a_err - $signed({3'b0, tot_q, 1'b0});
        end
        a_err_o = a_err[ErrW-1:0];
      end else if (27'(a_sum) < a_mark) begin
        a_res = (a_mark2 > a_tgt) ? a_tgt : a_mark2;
      end
    end else begin
      if (a_sum <= a_tgt) a_res = a_tgt;
      else if (a_inc == 0) begin
        a_err = a_err + (ErrW+1)'({absdif, 1'b0});
        if (a_err > $signed({4'b0, tot_q})) begin
          a_res = a_sum - 11'sd1;
          a_err = a_err - $signed({3'b0, tot_q, 1'b0});
        end
        a_err_o = a_err[ErrW-1:0];
      end else if (27'(a_sum) > a_mark) begin
        a_res = (a_mark2 < a_tgt) ? a_tgt : a_mark2;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc) begin
        if (kind_e'(iw.kind) == KIND_FADE) state_d = ST_DUR;
        else if (kind_e'(iw.kind) == KIND_TICK) state_d = fading_q ? ST_TICK : ST_OUT;
      end
      ST_DUR:  state_d = (tot_q == '0) ? ST_IDLE : ST_INC;
      ST_INC:  if (div_ctl.done && ch_q == 2'd2) state_d = ST_IDLE;
      ST_TICK: if (left_q == '0 || ch_q == 2'd2) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  logic [DurW-1:0] q_neg;
  always_comb begin
    fading_d = fading_q; shown_d = shown_q; cur_d = cur_q; tgt_d = tgt_q;
    dif_d = dif_q; inc_d = inc_q; err_d = err_q; tot_d = tot_q; left_d = left_q;
    ch_d = ch_q; active_d = active_q; ovalid_d = ovalid_q; ow_d = ow_q;
    div_start = 1'b0; div_num = absdif; div_den = tot_q;
    q_neg = DurW'(-17'({1'b0, quo}));
    if (out_ch.ready) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (acc) begin
        unique case (kind_e'(iw.kind))
          KIND_STILL: begin
            fading_d = 1'b0;
            shown_d = '{iw.red, iw.green, iw.blue};
          end
          KIND_FADE: begin
            fading_d = 1'b1;
            tot_d = steps;
            left_d = steps;
            ch_d = 2'd0;
            tgt_d = '{iw.red, iw.green, iw.blue};
            cur_d = shown_q;
            for (int c = 0; c < 3; c++) begin
              err_d[c] = '0;
              dif_d[c] = $signed({1'b0, tgt_d[c]}) - $signed({1'b0, shown_q[c]});
              inc_d[c] = '0;
            end
          end
          KIND_TICK: begin
            active_d = 1'b0;
            ch_d = 2'd0;
            if (fading_q) shown_d = cur_q;
          end
          KIND_NONE: ;
          default: ;
        endcase
      end
      ST_DUR: begin
        if (tot_q == '0) cur_d = tgt_q;
        else div_start = 1'b1;
      end
      ST_INC: if (div_ctl.done) begin
        inc_d[ch_q] = a_dif[IncW-1] ? IncW'(q_neg) : IncW'(quo);
        if (ch_q != 2'd2) begin
          ch_d = ch_q + 2'd1;
          div_start = 1'b1;
          div_num = (ch_q == 2'd0) ?
            (dif_q[1][IncW-1] ? DurW'(-20'(dif_q[1])) : DurW'(dif_q[1])) :
            (dif_q[2][IncW-1] ? DurW'(-20'(dif_q[2])) : DurW'(dif_q[2]));
          div_den = tot_q;
        end
      end
      ST_TICK: begin
        if (left_q == '0) fading_d = 1'b0;
        else begin
          cur_d[ch_q] = a_res[ColW-1:0];
          err_d[ch_q] = a_err_o;
          ch_d = ch_q + 2'd1;
          if (ch_q == 2'd2) begin
            left_d = left_q - DurW'(1);
            active_d = 1'b1;
          end
        end
      end
      ST_OUT: if (out_free) begin
        ovalid_d = 1'b1;
        ow_d = '{led_red: shown_q[0], led_green: shown_q[1], led_blue: shown_q[2],
                 fade_active: active_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; fading_q <= 1'b0; ovalid_q <= 1'b0; ch_q <= '0;
      active_q <= 1'b0; tot_q <= '0; left_q <= '0;
      for (int c = 0; c < 3; c++) begin
        shown_q[c] <= '0; cur_q[c] <= '0; tgt_q[c] <= '0;
        dif_q[c] <= '0; inc_q[c] <= '0; err_q[c] <= '0;
      end
    end else begin
      state_q <= state_d; fading_q <= fading_d; ovalid_q <= ovalid_d; ch_q <= ch_d;
      active_q <= active_d; tot_q <= tot_d; left_q <= left_d;
      shown_q <= shown_d; cur_q <= cur_d; tgt_q <= tgt_d;
      dif_q <= dif_d; inc_q <= inc_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) ow_q <= ow_d;

  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = ow_q;

  `ASSERT_ALWAYS(a_ready_idle, clk_i, rst_ni, !in_ch.ready || state_q == ST_IDLE, "ready when busy")
  `ASSERT_PROP(a_out_after, clk_i, rst_ni, $rose(ovalid_q) |-> $past(state_q) == ST_OUT, "stray out")
  `ASSERT_PROP(a_div_idle, clk_i, rst_ni, state_q == ST_IDLE |-> !div_ctl.busy, "div busy idle")
endmodule

>>> tb/sv/tb.sv
// Testbench for the RGB LED linear fader: directed and random words with a local fade predictor
`timescale 1ns / 1ps
module tb;
  import rlf_pkg::*;

  localparam int unsigned PeriodMs = 32;
  localparam int unsigned CycleLimit = 1500000;

  logic clk_i;
  logic rst_ni;

  rlf_if #(.T(in_word_t))  in_ch ();
  rlf_if #(.T(out_word_t)) out_ch ();

  rgb_led_linear_fader_core #(.RefreshPeriodMs(PeriodMs)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Predictor state
  logic        fading;
  logic [7:0]  shown [3];
  logic [7:0]  level [3];
  logic [7:0]  goal [3];
  int          diff [3];
  int          incr [3];
  int          err [3];
  int unsigned steps_total;
  int unsigned steps_rem;

  out_word_t   led_q[$];
  int          errors;
  int          mismatches;
  int          ticks_seen;
  int          fades_sent;
  int unsigned cycles;
  logic        stall_mode;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Advance one channel by one fade step
  function automatic void step_channel(int c);
    int cur;
    int sum;
    int mark;
    cur = level[c];
    sum = cur + incr[c];
    if (sum < 0) begin
      cur = 0;
    end else if (sum > 255) begin
      cur = 255;
    end else begin
      cur = sum;
      mark = int'(goal[c]) - int'(steps_rem) * incr[c];
      if (diff[c] > 0) begin
        if (cur >= goal[c]) begin
          cur = goal[c];
        end else if (incr[c] == 0) begin
          err[c] += 2 * diff[c];
          if (err[c] > int'(steps_total)) begin
            cur = cur + 1;
            err[c] -= 2 * int'(steps_total);
          end
        end else if (cur < mark) begin
          cur = cur + incr[c];
          if (cur > goal[c]) cur = goal[c];
        end
      end else begin
        if (cur <= goal[c]) begin
          cur = goal[c];
        end else if (incr[c] == 0) begin
          err[c] += 2 * (-diff[c]);
          if (err[c] > int'(steps_total)) begin
            cur = cur - 1;
            err[c] -= 2 * int'(steps_total);
          end
        end else if (cur > mark) begin
          cur = cur + incr[c];
          if (cur < goal[c]) cur = goal[c];
        end
      end
    end
    level[c] = cur[7:0];
  endfunction

  // Apply one accepted word to the predictor, queue the LED word on a tick
  function automatic void predict_fade(in_word_t w);
    logic [7:0] col [3];
    out_word_t  o;
    logic       act;
    col[0] = w.red;
    col[1] = w.green;
    col[2] = w.blue;
    case (w.kind)
      KIND_STILL: begin
        fading = 1'b0;
        for (int c = 0; c < 3; c++) shown[c] = col[c];
      end
      KIND_FADE: begin
        fading = 1'b1;
        steps_total = w.duration_ms / PeriodMs;
        steps_rem = steps_total;
        for (int c = 0; c < 3; c++) begin
          level[c] = shown[c];
          goal[c] = col[c];
          err[c] = 0;
          diff[c] = int'(col[c]) - int'(shown[c]);
          if (steps_total == 0) begin
            incr[c] = 0;
            level[c] = col[c];
          end else begin
            incr[c] = diff[c] / int'(steps_total);
          end
        end
      end
      KIND_TICK: begin
        act = 1'b0;
        if (fading) begin
          for (int c = 0; c < 3; c++) shown[c] = level[c];
          if (steps_rem != 0) begin
            steps_rem = steps_rem - 1;
            for (int c = 0; c < 3; c++) step_channel(c);
            act = 1'b1;
          end else begin
            fading = 1'b0;
          end
        end
        o.led_red = shown[0];
        o.led_green = shown[1];
        o.led_blue = shown[2];
        o.fade_active = act;
        led_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // Receiver: stall at random while stall_mode is set, check each word against the oldest expectation
  always @(negedge clk_i) begin
    if (stall_mode) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      ticks_seen++;
      if (led_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected LED word %h", out_ch.data);
      end else begin
        if (out_ch.data !== led_q[0]) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("tb: LED mismatch exp r=%0d g=%0d b=%0d a=%0b got r=%0d g=%0d b=%0d a=%0b",
                     led_q[0].led_red, led_q[0].led_green, led_q[0].led_blue,
                     led_q[0].fade_active, out_ch.data.led_red, out_ch.data.led_green,
                     out_ch.data.led_blue, out_ch.data.fade_active);
        end
        void'(led_q.pop_front());
      end
    end
  end

  int burst_left;

  // Send one word; idle in random gaps between bursts
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_fade(w);
    if (w.kind == KIND_FADE) fades_sent++;
    burst_left--;
    @(negedge clk_i);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_kind(kind_e k, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [15:0] d);
    in_word_t w;
    w.kind = k;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.duration_ms = d;
    send_word(w);
  endtask

  // Pause until every LED word has come
  task automatic drain_all();
    if (burst_left != 0) in_ch.valid <= 1'b0;
    burst_left = 0;
    while (led_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    send_kind(KIND_STILL, 8'd255, 8'd0, 8'd128, 16'hFFFF);
    send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    // zero step count snaps to target
    send_kind(KIND_FADE, 8'd0, 8'd255, 8'd7, 16'd31);
    repeat (2) send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    // unused kind is dropped
    send_kind(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    // small fades exercise the Bresenham path and catch-up
    send_kind(KIND_FADE, 8'd255, 8'd0, 8'd10, 16'd320);
    repeat (12) send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    send_kind(KIND_FADE, 8'd3, 8'd200, 8'd255, 16'd96);
    repeat (5) send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    drain_all();
  endtask

  task automatic test_long_fade();
    send_kind(KIND_STILL, 8'd0, 8'd255, 8'd0, 16'd0);
    send_kind(KIND_FADE, 8'd255, 8'd0, 8'd1, 16'hFFFF);
    repeat (40) send_kind(KIND_TICK, 8'd0, 8'd0, 8'd0, 16'd0);
    drain_all();
  endtask

  task automatic test_random(int n);
    int pick;
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) stall_mode = ~stall_mode;
      pick = $urandom_range(0, 99);
      w.red = $urandom_range(0, 255);
      w.green = $urandom_range(0, 255);
      w.blue = $urandom_range(0, 255);
      w.duration_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
      if (pick < 8) w.kind = KIND_FADE;
      else if (pick < 12) w.kind = KIND_STILL;
      else if (pick < 14) w.kind = KIND_NONE;
      else w.kind = KIND_TICK;
      send_word(w);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fading = 1'b0;
    steps_total = 0;
    steps_rem = 0;
    for (int c = 0; c < 3; c++) begin
      shown[c] = 0; level[c] = 0; goal[c] = 0;
      diff[c] = 0; incr[c] = 0; err[c] = 0;
    end
    errors = 0;
    mismatches = 0;
    ticks_seen = 0;
    fades_sent = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_long_fade();
    test_random(1650);
    drain_all();

    $display("tb: %0d LED words checked over %0d fade starts, %0d mismatches",
             ticks_seen, fades_sent, mismatches);
    if (errors == 0 && led_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/rlf_pkg.sv
rtl/rlf_if.sv
rtl/rlf_div.sv
rtl/rgb_led_linear_fader_core.sv
tb/sv/tb.sv
